// ===== hw/rtl/playfair_digraph_cipher_assert.svh =====
// Assertion helpers shared by the cipher RTL.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH

// Same-cycle implication, held off while reset is low.
`define PFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("playfair_digraph_cipher: same-cycle check failed");

// Next-cycle implication, held off while reset is low.
`define PFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("playfair_digraph_cipher: next-cycle check failed");

`endif

// ===== hw/rtl/pfc_pkg.sv =====
`timescale 1ns / 1ps

package pfc_pkg;

  localparam int LTR_W      = 5;
  localparam int SQ_N       = 5;
  localparam int ROW_W      = LTR_W * SQ_N;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROW_W;

  typedef logic [LTR_W-1:0]            letter_t;
  typedef logic [ROW_W-1:0]            row_t;
  typedef row_t [SQ_N-1:0]             square_t;

  localparam letter_t LTR_I = 5'd8;
  localparam letter_t LTR_J = 5'd9;
  localparam letter_t LTR_Q = 5'd16;
  localparam letter_t LTR_X = 5'd23;
  localparam letter_t LTR_Z = 5'd25;

  // A..Z without J, row-major, row 0 in the low slot.
  localparam square_t SQ_RESET = {25'd27025109, 25'd21613104, 25'd16201099,
                                  25'd10755269, 25'd4294688};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECRYPT = 3'd0,
    CFG_ROW0    = 3'd1,
    CFG_ROW1    = 3'd2,
    CFG_ROW2    = 3'd3,
    CFG_ROW3    = 3'd4,
    CFG_ROW4    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    letter_t a;
    letter_t b;
    logic    last;
  } digraph_t;

  typedef struct packed {
    logic in_busy;
    logic pend_vld;
    logic tail;
  } pair_stat_t;

endpackage

// ===== hw/rtl/pfc_in_if.sv =====
`timescale 1ns / 1ps

interface pfc_in_if;
  import pfc_pkg::*;

  logic    valid;
  logic    ready;
  letter_t letter_code;
  logic    message_end;

  modport source (output valid, letter_code, message_end, input ready);
  modport sink   (input valid, letter_code, message_end, output ready);
endinterface

// ===== hw/rtl/pfc_out_if.sv =====
`timescale 1ns / 1ps

interface pfc_out_if;
  import pfc_pkg::*;

  logic    valid;
  logic    ready;
  letter_t cipher_letter;
  logic    final_letter;

  modport source (output valid, cipher_letter, final_letter, input ready);
  modport sink   (input valid, cipher_letter, final_letter, output ready);
endinterface

// ===== hw/rtl/pfc_cipher.sv =====
`timescale 1ns / 1ps

module pfc_cipher (
  input  pfc_pkg::square_t  sq,
  input  logic              decrypt,
  input  pfc_pkg::digraph_t dg,
  output pfc_pkg::letter_t  ca,
  output pfc_pkg::letter_t  cb
);
  import pfc_pkg::*;

  localparam int POS_W = $clog2(SQ_N);
  typedef logic [POS_W-1:0] pos_t;
  localparam pos_t POS_LAST = pos_t'(SQ_N - 1);

  typedef struct packed {
    pos_t row;
    pos_t col;
  } loc_t;

  // First match in row-major order wins; a missing letter sits at row 0, column 0.
  function automatic loc_t locate(square_t s, letter_t ltr);
    loc_t loc;
    loc = '0;
    for (int r = SQ_N - 1; r >= 0; r--) begin
      for (int c = SQ_N - 1; c >= 0; c--) begin
        if (s[r][LTR_W*c +: LTR_W] == ltr) begin
          loc.row = pos_t'(r);
          loc.col = pos_t'(c);
        end
      end
    end
    return loc;
  endfunction

  function automatic pos_t step5(pos_t v, logic back);
    pos_t res;
    if (back) begin
      res = (v == '0) ? POS_LAST : pos_t'(v - 1'b1);
    end else begin
      res = (v == POS_LAST) ? '0 : pos_t'(v + 1'b1);
    end
    return res;
  endfunction

  function automatic letter_t cell_at(square_t s, pos_t r, pos_t c);
    return s[r][LTR_W*c +: LTR_W];
  endfunction

  loc_t la, lb, na, nb;

  always_comb begin
    la = locate(sq, dg.a);
    lb = locate(sq, dg.b);
    if (la.row == lb.row) begin
      na = '{row: la.row, col: step5(la.col, decrypt)};
      nb = '{row: lb.row, col: step5(lb.col, decrypt)};
    end else if (la.col == lb.col) begin
      na = '{row: step5(la.row, decrypt), col: la.col};
      nb = '{row: step5(lb.row, decrypt), col: lb.col};
    end else begin
      na = '{row: la.row, col: lb.col};
      nb = '{row: lb.row, col: la.col};
    end
  end

  assign ca = cell_at(sq, na.row, na.col);
  assign cb = cell_at(sq, nb.row, nb.col);

endmodule

// ===== hw/rtl/pfc_pair.sv =====
`timescale 1ns / 1ps

module pfc_pair (
  input  logic                clk,
  input  logic                rst_n,
  pfc_in_if.sink              in_ch,
  output logic                dg_valid,
  input  logic                dg_ready,
  output pfc_pkg::digraph_t   dg,
  output pfc_pkg::pair_stat_t stat
);
  import pfc_pkg::*;

  logic    in_vld_r, in_vld_nxt;
  letter_t in_letter_r;
  logic    in_end_r;
  logic    pend_vld_r, pend_vld_nxt;
  letter_t pend_letter_r, pend_letter_nxt;
  logic    tail_r, tail_nxt;
  logic    in_done;
  letter_t pad, fill;

  assign pad  = (in_letter_r == LTR_Z) ? LTR_X : LTR_Z;
  assign fill = (in_letter_r == LTR_X) ? LTR_Q : LTR_X;

  always_comb begin
    dg_valid        = 1'b0;
    dg              = '{a: in_letter_r, b: pad, last: 1'b1};
    in_done         = 1'b0;
    pend_vld_nxt    = pend_vld_r;
    pend_letter_nxt = pend_letter_r;
    tail_nxt        = tail_r;
    if (in_vld_r) begin
      if (tail_r) begin
        // second pass of a doubled tail: pad the repeated letter
        dg_valid = 1'b1;
        if (dg_ready) begin
          in_done         = 1'b1;
          tail_nxt        = 1'b0;
          pend_vld_nxt    = 1'b0;
          pend_letter_nxt = '0;
        end
      end else if (!pend_vld_r) begin
        if (in_end_r) begin
          dg_valid = 1'b1;
          in_done  = dg_ready;
        end else begin
          in_done         = 1'b1;
          pend_vld_nxt    = 1'b1;
          pend_letter_nxt = in_letter_r;
        end
      end else if (in_letter_r == pend_letter_r) begin
        dg_valid = 1'b1;
        dg       = '{a: pend_letter_r, b: fill, last: 1'b0};
        if (dg_ready) begin
          if (in_end_r) begin
            tail_nxt = 1'b1;
          end else begin
            in_done = 1'b1;
          end
        end
      end else begin
        dg_valid = 1'b1;
        dg       = '{a: pend_letter_r, b: in_letter_r, last: in_end_r};
        if (dg_ready) begin
          in_done         = 1'b1;
          pend_vld_nxt    = 1'b0;
          pend_letter_nxt = '0;
        end
      end
    end
  end

  assign in_ch.ready = !in_vld_r || in_done;
  assign in_vld_nxt  = in_ch.ready ? in_ch.valid : in_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      pend_vld_r    <= 1'b0;
      pend_letter_r <= '0;
      tail_r        <= 1'b0;
    end else begin
      in_vld_r      <= in_vld_nxt;
      pend_vld_r    <= pend_vld_nxt;
      pend_letter_r <= pend_letter_nxt;
      tail_r        <= tail_nxt;
    end
  end

  // fold J into I on the way in
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_letter_r <= (in_ch.letter_code == LTR_J) ? LTR_I : in_ch.letter_code;
      in_end_r    <= in_ch.message_end;
    end
  end

  assign stat = '{in_busy: in_vld_r, pend_vld: pend_vld_r, tail: tail_r};

endmodule

// ===== hw/rtl/playfair_digraph_cipher.sv =====
`timescale 1ns / 1ps
`include "playfair_digraph_cipher_assert.svh"
// Playfair digraph cipher over a 5x5 key square, streaming one letter per beat.
// in_ch   : letter_code (A=0..Z=25) and message_end on the last letter.
// out_ch  : cipher_letter, with final_letter on the last letter of a message.
// cfg_*   : write-only registers: decrypt_mode (index 0), square rows 0..4
//           (indexes 1..5, column k at bits 5k). Write only while idle.
// Letters pair into digraphs; a doubled letter gets an X (Q after X) filler,
// an odd tail gets a Z pad (X when the tail is Z).
// An input beat lands in the input register; the digraph is enciphered from it
// and loaded into the result register, from which its letters leave.
// Throughput: one input beat per cycle while letters only pair up and out_ch
// does not stall; each digraph takes two output beats from the result register.
// A letter that makes a filler and a pad stays in the input register until the
// pad pair loads, since the pad pair waits for both beats of the filler pair.
// Reset (rst_n low, synchronous) empties all stages, drops any open digraph
// and loads encrypt mode with the A..Z-without-J square.
// When out_ch stalls, the result register holds its pair and the input
// register fills; in_ch.ready then drops until the result register frees.
module playfair_digraph_cipher (
  input  logic                            clk,
  input  logic                            rst_n,
  pfc_in_if.sink                          in_ch,
  pfc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pfc_pkg::*;

  // configuration registers
  logic    decrypt_r;
  square_t square_r;

  // pairing stage to cipher
  logic       dg_valid;
  logic       dg_ready;
  digraph_t   dg;
  pair_stat_t pair_stat;
  letter_t    ca, cb;

  // result register: one enciphered pair, sent a letter per beat
  logic    pr_vld_r, pr_vld_nxt;
  logic    pr_idx_r, pr_idx_nxt;
  letter_t pr_a_r, pr_b_r;
  logic    pr_last_r;
  logic    out_beat;
  logic    pr_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_r <= 1'b0;
      square_r  <= SQ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_DECRYPT: decrypt_r   <= cfg_wdata[0];
        CFG_ROW0:    square_r[0] <= cfg_wdata;
        CFG_ROW1:    square_r[1] <= cfg_wdata;
        CFG_ROW2:    square_r[2] <= cfg_wdata;
        CFG_ROW3:    square_r[3] <= cfg_wdata;
        CFG_ROW4:    square_r[4] <= cfg_wdata;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  pfc_pair u_pair (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dg_valid (dg_valid),
    .dg_ready (dg_ready),
    .dg       (dg),
    .stat     (pair_stat)
  );

  pfc_cipher u_cipher (
    .sq      (square_r),
    .decrypt (decrypt_r),
    .dg      (dg),
    .ca      (ca),
    .cb      (cb)
  );

  assign out_beat = out_ch.valid && out_ch.ready;
  // the slot frees on the beat that sends the second letter
  assign dg_ready = !pr_vld_r || (out_beat && pr_idx_r);
  assign pr_load  = dg_valid && dg_ready;

  always_comb begin
    pr_vld_nxt = pr_vld_r;
    pr_idx_nxt = pr_idx_r;
    if (pr_load) begin
      pr_vld_nxt = 1'b1;
      pr_idx_nxt = 1'b0;
    end else if (out_beat) begin
      pr_vld_nxt = !pr_idx_r;
      pr_idx_nxt = !pr_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_vld_r <= 1'b0;
      pr_idx_r <= 1'b0;
    end else begin
      pr_vld_r <= pr_vld_nxt;
      pr_idx_r <= pr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pr_load) begin
      pr_a_r    <= ca;
      pr_b_r    <= cb;
      pr_last_r <= dg.last;
    end
  end

  assign out_ch.valid         = pr_vld_r;
  assign out_ch.cipher_letter = pr_idx_r ? pr_b_r : pr_a_r;
  assign out_ch.final_letter  = pr_idx_r && pr_last_r;

  // input side stalls only behind an occupied input register
  `PFC_ASSERT_IMP(a_stall_needs_item, clk, rst_n, !in_ch.ready, pair_stat.in_busy)
  // a doubled tail keeps its open digraph until the pad pair loads into the result register
  `PFC_ASSERT_IMP(a_tail_has_pending, clk, rst_n, pair_stat.tail, pair_stat.pend_vld)
  // a stalled result keeps its place in the pair
  `PFC_ASSERT_NXT(a_stall_holds_pair, clk, rst_n, pr_vld_r && !out_ch.ready, pr_vld_r && $stable(pr_idx_r))

endmodule
